@@ sv/sps_pkg.sv @@
// shared widths, state codes and result type for the prime sieve statistics block
package sps_pkg;

    localparam int MAP_SIZE_DEF = 1024;
    localparam int LIMIT_W      = 10;
    localparam int COUNT_W      = 10;
    localparam int SUM_W        = 18;
    // walking index reaches limit + p, one bit above the limit
    localparam int IDX_W        = LIMIT_W + 1;
    // base prime stays at or below 32 since 32 * 32 exceeds the largest limit
    localparam int P_W          = 6;
    localparam int PSQ_W        = 2 * P_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_PCHK  = 7'b0000100,
        ST_PWAIT = 7'b0001000,
        ST_MARK  = 7'b0010000,
        ST_SCAN  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } sps_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] prime_count;
        logic [SUM_W-1:0]   prime_sum;
        logic               even_prime_count;
        logic [COUNT_W-1:0] odd_prime_count;
    } sps_result_t;

endpackage

@@ sv/sps_bitmap.sv @@
// composite bitmap memory, one bit per number, registered read
module sps_bitmap import sps_pkg::*; #(
    parameter int MAP_SIZE = MAP_SIZE_DEF,
    localparam int AW = $clog2(MAP_SIZE)
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic          wdata,
    output logic          rdata
);

    logic mem [MAP_SIZE];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/sps_engine.sv @@
// sieve sequencer: clear, mark multiples and scan the bitmap memory
module sps_engine import sps_pkg::*; #(
    parameter int MAP_SIZE = MAP_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [LIMIT_W-1:0] limit_in,
    output logic               ready,
    output logic               done,
    input  logic               take,
    output sps_result_t        result
);

    localparam int AW = $clog2(MAP_SIZE);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX =
        (MAP_SIZE - 1 > (1 << LIMIT_W) - 1) ? {LIMIT_W{1'b1}} : LIMIT_W'(MAP_SIZE - 1);

    sps_state_t         state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   ridx_reg, ridx_next;
    logic               rvld_reg, rvld_next;
    logic [IDX_W-1:0]   m_reg, m_next;
    logic [P_W-1:0]     p_reg, p_next;
    sps_result_t        acc_reg, acc_next;

    logic [PSQ_W-1:0]   psq;
    logic [IDX_W-1:0]   limit_ext;
    logic               mem_en, mem_we, mem_wdata, mem_rdata;
    logic [AW-1:0]      mem_addr;

    assign psq       = {{P_W{1'b0}}, p_reg} * {{P_W{1'b0}}, p_reg};
    assign limit_ext = {1'b0, limit_reg};

    sps_bitmap #(.MAP_SIZE(MAP_SIZE)) u_bitmap (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next = state_reg;
        limit_next = limit_reg;
        idx_next   = idx_reg;
        ridx_next  = ridx_reg;
        rvld_next  = rvld_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = 1'b0;
        mem_addr   = AW'(idx_reg);
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    limit_next = (limit_in > LIMIT_MAX) ? LIMIT_MAX : limit_in;
                    idx_next   = IDX_W'(2);
                    acc_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (idx_reg > limit_ext) begin
                    p_next     = P_W'(2);
                    state_next = ST_PCHK;
                end else begin
                    mem_en   = 1'b1;
                    mem_we   = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_PCHK: begin
                if (psq > {{(PSQ_W - LIMIT_W){1'b0}}, limit_reg}) begin
                    idx_next   = IDX_W'(2);
                    rvld_next  = 1'b0;
                    state_next = ST_SCAN;
                end else begin
                    mem_en     = 1'b1;
                    mem_addr   = AW'(p_reg);
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT: begin
                if (mem_rdata) begin
                    p_next     = p_reg + P_W'(1);
                    state_next = ST_PCHK;
                end else begin
                    m_next     = IDX_W'(psq);
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                if (m_reg > limit_ext) begin
                    p_next     = p_reg + P_W'(1);
                    state_next = ST_PCHK;
                end else begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = 1'b1;
                    mem_addr  = AW'(m_reg);
                    m_next    = m_reg + {{(IDX_W - P_W){1'b0}}, p_reg};
                end
            end
            ST_SCAN: begin
                // bit for ridx arrives in the cycle after its read
                if (rvld_reg && !mem_rdata) begin
                    acc_next.prime_count = acc_reg.prime_count + COUNT_W'(1);
                    acc_next.prime_sum   = acc_reg.prime_sum + SUM_W'(ridx_reg);
                    if (ridx_reg[0]) begin
                        acc_next.odd_prime_count = acc_reg.odd_prime_count + COUNT_W'(1);
                    end else begin
                        acc_next.even_prime_count = acc_reg.even_prime_count + 1'b1;
                    end
                end
                if (idx_reg <= limit_ext) begin
                    mem_en    = 1'b1;
                    ridx_next = idx_reg;
                    rvld_next = 1'b1;
                    idx_next  = idx_reg + IDX_W'(1);
                end else begin
                    rvld_next = 1'b0;
                    if (!rvld_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rvld_reg  <= rvld_next;
        end
        limit_reg <= limit_next;
        idx_reg   <= idx_next;
        ridx_reg  <= ridx_next;
        m_reg     <= m_next;
        p_reg     <= p_next;
        acc_reg   <= acc_next;
    end

    assign ready  = (state_reg == ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign result = acc_reg;

endmodule

@@ sv/prime_sieve_statistics_top.sv @@
// top level of the prime sieve statistics block with output register
//
// usage
//   input channel s_: one request carries upper_limit; the block sieves
//   2..upper_limit (saturated at MAP_SIZE - 1) in a one-bit composite bitmap
//   output channel m_: one result per request with prime count, prime sum,
//   even prime count and odd prime count; a limit below two gives all zeros
// throughput
//   one request at a time; the time from acceptance to m_valid is set by the
//   single port of the bitmap memory: one clearing write per number, one write
//   per marked multiple, a read and a wait per base candidate and one read per
//   number in the final scan
// stall behavior
//   the finished result moves into the output register, so a new request is
//   taken while the previous result still waits for m_ready; if the output
//   register is still full when the next result is done, the sequencer holds
//   it until the register frees up
// reset
//   aresetn is synchronous and active low; it empties the output register and
//   returns the sequencer to idle; the bitmap needs no reset since each
//   request clears 2..limit before marking
module prime_sieve_statistics_top import sps_pkg::*; #(
    parameter int MAP_SIZE = MAP_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [LIMIT_W-1:0] s_upper_limit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_prime_count,
    output logic [SUM_W-1:0]   m_prime_sum,
    output logic               m_even_prime_count,
    output logic [COUNT_W-1:0] m_odd_prime_count
);

    logic        eng_ready;
    logic        eng_done;
    logic        take;
    sps_result_t eng_result;

    logic        m_valid_reg, m_valid_next;
    sps_result_t res_reg, res_next;

    // sequencer: clear, mark and scan through the bitmap memory
    sps_engine #(.MAP_SIZE(MAP_SIZE)) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid),
        .limit_in (s_upper_limit),
        .ready    (eng_ready),
        .done     (eng_done),
        .take     (take),
        .result   (eng_result)
    );

    assign s_ready = eng_ready;

    // output register frees up when empty or being drained this cycle
    assign take = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (take) begin
            m_valid_next = eng_done;
            if (eng_done) begin
                res_next = eng_result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        res_reg <= res_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_prime_count      = res_reg.prime_count;
    assign m_prime_sum        = res_reg.prime_sum;
    assign m_even_prime_count = res_reg.even_prime_count;
    assign m_odd_prime_count  = res_reg.odd_prime_count;

    // total count splits exactly into even and odd primes
    a_count_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_prime_count == m_odd_prime_count + COUNT_W'(m_even_prime_count))
        else $error("prime count differs from even plus odd count");

    // any odd prime means the limit reached 3, so 2 was counted as well
    a_two_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_odd_prime_count != '0 |-> m_even_prime_count)
        else $error("odd primes reported without the even prime");

    // an accepted request keeps the sequencer busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while sequencer still busy");

    // a sum of zero goes only with a count of zero
    a_sum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_prime_sum == '0 |-> m_prime_count == '0)
        else $error("primes counted with zero sum");

endmodule
